[src/frc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the header byte layout of the frame capture ring writer.
// No dependencies; every other file in src imports this package.
package frc_pkg;

   // Capture memory geometry and header layout
   localparam int CAPTURE_BYTES         = 2048;
   localparam int INDEX_W               = 11;
   localparam int HEADER_BYTES          = 5;
   localparam int INDEX_FIELD_OFFSET    = 1;
   localparam int SEQUENCE_FIELD_OFFSET = 3;
   localparam int BEAT_W                = 3;

   // Input command codes
   typedef enum logic [1:0] {
      CMD_RADIO   = 2'd0,
      CMD_PAYLOAD = 2'd1,
      CMD_ACK     = 2'd2,
      CMD_UNUSED  = 2'd3
   } command_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_MIN_LENGTH  = 2'd0,
      CSR_MAX_LENGTH  = 2'd1,
      CSR_RSSI_OFFSET = 2'd2,
      CSR_END_MARKER  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [6:0] min_frame_length;
      logic [6:0] max_frame_length;
      logic [7:0] rssi_offset;
      logic [7:0] end_marker;
   } cfg_type;

   // One accepted item's worth of results: either a single beat or a header burst
   typedef struct packed {
      logic                  header;
      logic                  wrap;
      logic [BEAT_W-1:0]     last_beat;
      logic [INDEX_W-1:0]    old_index;
      logic [7:0]            marker;
      logic [INDEX_W-1:0]    base;
      logic [7:0]            total;
      logic [15:0]           seq;
      logic                  write_enable;
      logic [INDEX_W-1:0]    write_address;
      logic [7:0]            write_data;
      logic                  flush;
      logic                  activity;
      logic                  loss;
   } burst_type;

   // Header byte idx: total length, write index and sequence number, high byte first.
   // Sequence fields are placed last so they win where the two fields overlap.
   function automatic logic [7:0] header_byte(input logic [BEAT_W-1:0]  idx,
                                              input logic [7:0]         total,
                                              input logic [INDEX_W-1:0] index,
                                              input logic [15:0]        seq);
      logic [7:0]  hdr [HEADER_BYTES];
      logic [15:0] index_wide;
      index_wide = 16'(index);
      for (int k = 0; k < HEADER_BYTES; k++) begin
         hdr[k] = 8'd0;
      end
      hdr[0]                         = total;
      hdr[INDEX_FIELD_OFFSET]        = index_wide[15:8];
      hdr[INDEX_FIELD_OFFSET + 1]    = index_wide[7:0];
      hdr[SEQUENCE_FIELD_OFFSET]     = seq[15:8];
      hdr[SEQUENCE_FIELD_OFFSET + 1] = seq[7:0];
      if (int'(idx) < HEADER_BYTES) begin
         return hdr[idx];
      end
      return 8'd0;
   endfunction

endpackage

[src/frc_csr.sv]
`timescale 1ns / 1ps
// Configuration registers of the frame capture ring writer.
// Depends on frc_pkg for the register index codes and the cfg_type bundle.
module frc_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  frc_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_write_data,
   output frc_pkg::cfg_type       cfg
);
   import frc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_LENGTH:  cfg_in.min_frame_length = csr_write_data[6:0];
            CSR_MAX_LENGTH:  cfg_in.max_frame_length = csr_write_data[6:0];
            CSR_RSSI_OFFSET: cfg_in.rssi_offset      = csr_write_data;
            CSR_END_MARKER:  cfg_in.end_marker       = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_frame_length <= 7'd4;
         cfg_ff.max_frame_length <= 7'd127;
         cfg_ff.rssi_offset      <= 8'd73;
         cfg_ff.end_marker       <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/frc_tracker.sv]
`timescale 1ns / 1ps
// Ring state and per-beat decision logic: checks frames, updates indexes and
// registers one burst descriptor per accepted beat. Depends on frc_pkg.
module frc_tracker (
   input  logic                       clock,
   input  logic                       reset,
   input  frc_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  frc_pkg::command_type       req_command,
   input  logic                       req_frame_done,
   input  logic                       req_start_of_frame,
   input  logic [7:0]                 req_length_byte,
   input  logic [7:0]                 req_fifo_count,
   input  logic [7:0]                 req_payload_byte,
   input  logic [frc_pkg::INDEX_W-1:0] req_acked_position,
   input  logic                       desc_release,
   output logic                       desc_valid,
   output frc_pkg::burst_type         desc
);
   import frc_pkg::*;

   logic [INDEX_W-1:0] write_index_ff, write_index_in;
   logic [INDEX_W-1:0] reader_index_ff, reader_index_in;
   logic [15:0]        sequence_ff, sequence_in;
   logic [7:0]         payload_left_ff, payload_left_in;
   logic [INDEX_W-1:0] payload_address_ff, payload_address_in;
   logic               loss_ff, loss_in;
   logic               activity_ff, activity_in;
   logic               desc_valid_ff, desc_valid_in;
   burst_type          desc_ff, desc_in;

   logic               accept;
   logic [8:0]         full;
   logic [INDEX_W:0]   wsum;
   logic               wraps;
   logic               bad_frame;
   logic               no_space;
   logic               do_flush;
   logic [INDEX_W-1:0] base;

   // The descriptor slot frees when its last beat moves to the output register
   assign req_stall = desc_valid_ff && !desc_release;
   assign accept    = req_valid && !req_stall;

   // Frame checks
   always_comb begin
      full      = 9'(req_length_byte) + 9'(HEADER_BYTES);
      wsum      = (INDEX_W+1)'(write_index_ff) + (INDEX_W+1)'(full);
      wraps     = wsum >= (INDEX_W+1)'(CAPTURE_BYTES);
      bad_frame = (req_length_byte > 8'(cfg.max_frame_length))
               || (req_length_byte < 8'(cfg.min_frame_length))
               || (req_length_byte != req_fifo_count);
      if (wraps) begin
         no_space = (reader_index_ff > write_index_ff)
                 || (9'(reader_index_ff) <= full && reader_index_ff < 11'd512);
      end else begin
         no_space = (reader_index_ff > write_index_ff)
                 && ((INDEX_W+1)'(reader_index_ff) <= wsum);
      end
      base = wraps ? '0 : write_index_ff;
   end

   // Next state and descriptor for the accepted beat
   always_comb begin
      write_index_in     = write_index_ff;
      reader_index_in    = reader_index_ff;
      sequence_in        = sequence_ff;
      payload_left_in    = payload_left_ff;
      payload_address_in = payload_address_ff;
      loss_in            = loss_ff;
      activity_in        = activity_ff;
      do_flush           = 1'b0;
      desc_in            = '0;

      case (req_command)
         CMD_RADIO: begin
            if (req_frame_done) begin
               if (bad_frame) begin
                  do_flush = 1'b1;
               end else if (no_space) begin
                  do_flush = 1'b1;
                  loss_in  = 1'b1;
               end else begin
                  desc_in.header     = 1'b1;
                  desc_in.wrap       = wraps;
                  desc_in.last_beat  = wraps ? BEAT_W'(HEADER_BYTES) : BEAT_W'(HEADER_BYTES - 1);
                  desc_in.old_index  = write_index_ff;
                  desc_in.marker     = cfg.end_marker;
                  desc_in.base       = base;
                  desc_in.total      = full[7:0];
                  desc_in.seq        = sequence_ff;
                  sequence_in        = sequence_ff + 16'd1;
                  payload_address_in = base + INDEX_W'(HEADER_BYTES);
                  payload_left_in    = req_length_byte;
                  write_index_in     = base + INDEX_W'(full);
                  if (req_length_byte == 8'd0) begin
                     activity_in = 1'b0;
                  end
               end
            end else if (req_start_of_frame) begin
               activity_in = 1'b1;
            end else begin
               do_flush = 1'b1;
            end
         end
         CMD_PAYLOAD: begin
            if (payload_left_ff != 8'd0) begin
               desc_in.write_enable  = 1'b1;
               desc_in.write_address = payload_address_ff;
               // RSSI byte arrives when two bytes remain
               desc_in.write_data    = (payload_left_ff == 8'd2)
                                     ? req_payload_byte - cfg.rssi_offset
                                     : req_payload_byte;
               payload_address_in    = payload_address_ff + INDEX_W'(1);
               payload_left_in       = payload_left_ff - 8'd1;
               if (payload_left_ff == 8'd1) begin
                  activity_in = 1'b0;
               end
            end
         end
         CMD_ACK: begin
            reader_index_in = req_acked_position;
         end
         default: begin
            reader_index_in = reader_index_ff;
         end
      endcase

      if (do_flush) begin
         activity_in     = 1'b0;
         payload_left_in = 8'd0;
         desc_in.flush   = 1'b1;
      end
      desc_in.activity = activity_in;
      desc_in.loss     = loss_in;
   end

   assign desc_valid_in = accept || (desc_valid_ff && !desc_release);

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff     <= '0;
         reader_index_ff    <= '0;
         sequence_ff        <= '0;
         payload_left_ff    <= '0;
         payload_address_ff <= '0;
         loss_ff            <= 1'b0;
         activity_ff        <= 1'b0;
         desc_valid_ff      <= 1'b0;
      end else begin
         desc_valid_ff <= desc_valid_in;
         if (accept) begin
            write_index_ff     <= write_index_in;
            reader_index_ff    <= reader_index_in;
            sequence_ff        <= sequence_in;
            payload_left_ff    <= payload_left_in;
            payload_address_ff <= payload_address_in;
            loss_ff            <= loss_in;
            activity_ff        <= activity_in;
         end
      end
   end

   // Descriptor payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

   assign desc_valid = desc_valid_ff;
   assign desc       = desc_ff;

`ifndef ASSERT_OFF
   // A wrapping header always restarts at the bottom of memory
   assert property (@(posedge clock) disable iff (reset)
      desc_valid_ff && desc_ff.header && desc_ff.wrap |-> desc_ff.base == '0)
      else $error("wrapping header not based at address zero");

   // Burst length follows the descriptor kind
   assert property (@(posedge clock) disable iff (reset)
      desc_valid_ff |-> (desc_ff.header ? (desc_ff.last_beat == (desc_ff.wrap
         ? BEAT_W'(HEADER_BYTES) : BEAT_W'(HEADER_BYTES - 1))) : (desc_ff.last_beat == '0)))
      else $error("descriptor burst length inconsistent");

   // A flush always leaves no payload pending
   assert property (@(posedge clock) disable iff (reset)
      accept && do_flush |=> payload_left_ff == 8'd0 && !activity_ff)
      else $error("flush left payload pending or activity on");
`endif

endmodule

[src/frc_emitter.sv]
`timescale 1ns / 1ps
// Beat sequencer and result register: walks a burst descriptor out one
// result beat at a time. Depends on frc_pkg.
module frc_emitter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        desc_valid,
   input  frc_pkg::burst_type          desc,
   output logic                        desc_release,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_write_enable,
   output logic [frc_pkg::INDEX_W-1:0] rsp_write_address,
   output logic [7:0]                  rsp_write_data,
   output logic                        rsp_flush_receiver,
   output logic                        rsp_activity_on,
   output logic                        rsp_loss_seen,
   output logic                        rsp_last
);
   import frc_pkg::*;

   logic [BEAT_W-1:0]  beat_ff, beat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_write_enable_ff;
   logic [INDEX_W-1:0] rsp_write_address_ff;
   logic [7:0]         rsp_write_data_ff;
   logic               rsp_flush_receiver_ff;
   logic               rsp_activity_on_ff;
   logic               rsp_loss_seen_ff;
   logic               rsp_last_ff;

   logic               out_load;
   logic               take;
   logic               is_last;
   logic [BEAT_W-1:0]  hdr_idx;
   logic               beat_we;
   logic [INDEX_W-1:0] beat_addr;
   logic [7:0]         beat_data;

   assign out_load     = !rsp_valid_ff || !rsp_stall;
   assign take         = desc_valid && out_load;
   assign is_last      = beat_ff == desc.last_beat;
   assign desc_release = take && is_last;

   // Current beat contents
   always_comb begin
      hdr_idx   = desc.wrap ? beat_ff - BEAT_W'(1) : beat_ff;
      beat_we   = desc.write_enable;
      beat_addr = desc.write_address;
      beat_data = desc.write_data;
      if (desc.header) begin
         beat_we = 1'b1;
         if (desc.wrap && beat_ff == '0) begin
            beat_addr = desc.old_index;
            beat_data = desc.marker;
         end else begin
            beat_addr = desc.base + INDEX_W'(hdr_idx);
            beat_data = header_byte(hdr_idx, desc.total, desc.base, desc.seq);
         end
      end
   end

   always_comb begin
      beat_in = beat_ff;
      if (take) begin
         beat_in = is_last ? '0 : beat_ff + BEAT_W'(1);
      end
      rsp_valid_in = out_load ? desc_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_write_enable_ff   <= beat_we;
         rsp_write_address_ff  <= beat_addr;
         rsp_write_data_ff     <= beat_data;
         rsp_flush_receiver_ff <= desc.flush;
         rsp_activity_on_ff    <= desc.activity;
         rsp_loss_seen_ff      <= desc.loss;
         rsp_last_ff           <= is_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_write_enable   = rsp_write_enable_ff;
   assign rsp_write_address  = rsp_write_address_ff;
   assign rsp_write_data     = rsp_write_data_ff;
   assign rsp_flush_receiver = rsp_flush_receiver_ff;
   assign rsp_activity_on    = rsp_activity_on_ff;
   assign rsp_loss_seen      = rsp_loss_seen_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef ASSERT_OFF
   // The beat counter never runs past the burst
   assert property (@(posedge clock) disable iff (reset)
      desc_valid |-> beat_ff <= desc.last_beat)
      else $error("beat counter beyond burst length");

   // A flush beat is a lone, non-writing beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flush_receiver_ff |-> rsp_last_ff && !rsp_write_enable_ff)
      else $error("flush beat writes or is not last");

   // Non-writing beats carry zero address and data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_write_enable_ff |->
         rsp_write_address_ff == '0 && rsp_write_data_ff == 8'd0)
      else $error("idle beat carries address or data");
`endif

endmodule

[src/frame_capture_ring_writer_core.sv]
`timescale 1ns / 1ps
// Frame capture ring writer: usage notes
//   req_* channel (valid/stall): one beat per radio event, payload byte or
//     reader acknowledge. rsp_* channel (valid/stall): capture memory writes,
//     receiver flush requests and indicator levels; rsp_last marks the final
//     result beat of each request beat.
//   csr_* port: plain write port for min/max frame length, RSSI offset and
//     end marker; write only while the block is idle.
//   Flow: an accepted request is registered in the descriptor slot, and its
//     first result then in the result register. Payload, acknowledge and
//     start-of-frame beats give one result each and flow at one beat per
//     cycle unless the receiver stalls. An accepted frame-done gives five
//     header results, six when the ring wraps; the burst leaves the single
//     descriptor slot at the same rate, and the request side stalls behind it.
//   The descriptor slot and the result register are separate, so one request
//   is taken while a result waits on a stalled receiver; further requests stall
//   until the receiver drains. Results are never dropped or repeated.
//   Reset (synchronous, active high) clears indexes, sequence number, pending
//   payload and both flags, and loads the register defaults.
// Depends on frc_pkg, frc_csr, frc_tracker and frc_emitter.
module frame_capture_ring_writer_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [7:0]                  csr_write_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_command,
   input  logic                        req_frame_done,
   input  logic                        req_start_of_frame,
   input  logic [7:0]                  req_length_byte,
   input  logic [7:0]                  req_fifo_count,
   input  logic [7:0]                  req_payload_byte,
   input  logic [frc_pkg::INDEX_W-1:0] req_acked_position,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_write_enable,
   output logic [frc_pkg::INDEX_W-1:0] rsp_write_address,
   output logic [7:0]                  rsp_write_data,
   output logic                        rsp_flush_receiver,
   output logic                        rsp_activity_on,
   output logic                        rsp_loss_seen,
   output logic                        rsp_last
);
   import frc_pkg::*;

   cfg_type   cfg;
   burst_type desc;
   logic      desc_valid;
   logic      desc_release;

   // Configuration registers
   frc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index_type'(csr_index)),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Ring state and frame checks
   frc_tracker u_tracker (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (command_type'(req_command)),
      .req_frame_done     (req_frame_done),
      .req_start_of_frame (req_start_of_frame),
      .req_length_byte    (req_length_byte),
      .req_fifo_count     (req_fifo_count),
      .req_payload_byte   (req_payload_byte),
      .req_acked_position (req_acked_position),
      .desc_release       (desc_release),
      .desc_valid         (desc_valid),
      .desc               (desc)
   );

   // Result beat sequencer
   frc_emitter u_emitter (
      .clock              (clock),
      .reset              (reset),
      .desc_valid         (desc_valid),
      .desc               (desc),
      .desc_release       (desc_release),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_write_enable   (rsp_write_enable),
      .rsp_write_address  (rsp_write_address),
      .rsp_write_data     (rsp_write_data),
      .rsp_flush_receiver (rsp_flush_receiver),
      .rsp_activity_on    (rsp_activity_on),
      .rsp_loss_seen      (rsp_loss_seen),
      .rsp_last           (rsp_last)
   );

endmodule
